[rtl/uwsp_pkg.sv]
`default_nettype none

package uwsp_pkg;

    localparam int NODE_W     = 6;
    localparam int NODE_SLOTS = 2 ** NODE_W;
    localparam int LEN_W      = NODE_W + 1;

    // request op codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] path_node;
        logic [NODE_W-1:0] hop_index;
        logic              last;
        logic              edges_dropped;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic q_init;
        logic deq_rd;
        logic deq_load;
        logic scan_step;
        logic walk_init;
        logic walk_rd;
        logic walk_step;
        logic emit_init;
        logic emit_rd;
        logic emit_load;
        logic nf_load;
    } cmd_t;

    typedef struct packed {
        logic       req_valid;
        logic [1:0] req_op;
        logic       query_ok;
        logic       fifo_empty;
        logic       scan_done;
        logic       end_visited;
        logic       walk_done;
        logic       emit_last;
        logic       out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/uwsp_ram.sv]
`default_nettype none

module uwsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/uwsp_ctrl.sv]
`default_nettype none

module uwsp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire uwsp_pkg::status_t status,
    output uwsp_pkg::cmd_t         cmd,
    output logic                   busy
);

    import uwsp_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEQ     = 4'd1;
    localparam logic [3:0] S_DEQW    = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_CHK     = 4'd4;
    localparam logic [3:0] S_WALK    = 4'd5;
    localparam logic [3:0] S_WALKW   = 4'd6;
    localparam logic [3:0] S_EMIT_RD = 4'd7;
    localparam logic [3:0] S_EMIT_WR = 4'd8;
    localparam logic [3:0] S_NF      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (status.req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.req_op == OP_QUERY)
                    begin
                        if (status.query_ok)
                        begin
                            cmd.q_init = 1'b1;
                            state_next = S_DEQ;
                        end
                        else
                        begin
                            state_next = S_NF;
                        end
                    end
                end
            end
            S_DEQ:
            begin
                if (status.fifo_empty)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    cmd.deq_rd = 1'b1;
                    state_next = S_DEQW;
                end
            end
            S_DEQW:
            begin
                cmd.deq_load = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_DEQ;
                end
            end
            S_CHK:
            begin
                if (status.end_visited)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK;
                end
                else
                begin
                    state_next = S_NF;
                end
            end
            S_WALK:
            begin
                if (status.walk_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_EMIT_RD;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALKW;
                end
            end
            S_WALKW:
            begin
                cmd.walk_step = 1'b1;
                state_next    = S_WALK;
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_NF:
            begin
                if (status.out_free)
                begin
                    cmd.nf_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[rtl/uwsp_dp.sv]
`default_nettype none

module uwsp_dp #(
    parameter int NODES     = 64,
    parameter int MAX_EDGES = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire uwsp_pkg::req_t    req_data,
    input  wire uwsp_pkg::cmd_t    cmd,
    output uwsp_pkg::status_t      status,
    output logic                   rsp_valid,
    output uwsp_pkg::rsp_t         rsp_data,
    input  wire logic              rsp_stall
);

    import uwsp_pkg::*;

    localparam int EA = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);

    logic [CW-1:0]     count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [NODE_W-1:0] start_reg, start_next;
    logic [NODE_W-1:0] end_reg, end_next;
    logic [NODE_W-1:0] u_reg, u_next;
    logic [CW-1:0]     e_reg, e_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  head_reg, head_next;
    logic [LEN_W-1:0]  tail_reg, tail_next;
    logic [NODE_SLOTS-1:0] visited_reg, visited_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [NODE_W-1:0] k_reg, k_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic a_ok, b_ok, full, add_en, issue, hit, tgt_ok, last_hop;
    logic [2*NODE_W-1:0] edge_wr, edge_rd;
    logic [NODE_W-1:0]   src, tgt, fifo_rd, parent_rd, stack_rd;

    assign a_ok   = (int'(req_data.node_a) < NODES);
    assign b_ok   = (int'(req_data.node_b) < NODES);
    assign full   = (count_reg == CW'(MAX_EDGES));
    assign add_en = cmd.accept && (req_data.op == OP_ADD) && a_ok && b_ok && !full;
    assign issue  = cmd.scan_step && (e_reg != count_reg);
    assign src    = edge_rd[2*NODE_W-1:NODE_W];
    assign tgt    = edge_rd[NODE_W-1:0];
    assign tgt_ok = (int'(tgt) < NODES);
    // first discovery of an unvisited neighbour of the dequeued node
    assign hit    = cmd.scan_step && pend_reg && (src == u_reg) && tgt_ok
                    && !visited_reg[tgt];
    assign last_hop = ((LEN_W'(k_reg) + LEN_W'(1)) == len_reg);
    assign edge_wr  = {req_data.node_a, req_data.node_b};

    uwsp_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk     (clk),
        .wr_en   (add_en),
        .wr_addr (count_reg[EA-1:0]),
        .wr_data (edge_wr),
        .rd_en   (issue),
        .rd_addr (e_reg[EA-1:0]),
        .rd_data (edge_rd)
    );

    uwsp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_fifo_ram (
        .clk     (clk),
        .wr_en   (cmd.q_init || hit),
        .wr_addr (cmd.q_init ? NODE_W'(0) : tail_reg[NODE_W-1:0]),
        .wr_data (cmd.q_init ? req_data.node_a : tgt),
        .rd_en   (cmd.deq_rd),
        .rd_addr (head_reg[NODE_W-1:0]),
        .rd_data (fifo_rd)
    );

    uwsp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_parent_ram (
        .clk     (clk),
        .wr_en   (hit),
        .wr_addr (tgt),
        .wr_data (u_reg),
        .rd_en   (cmd.walk_rd),
        .rd_addr (cur_reg),
        .rd_data (parent_rd)
    );

    uwsp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_stack_ram (
        .clk     (clk),
        .wr_en   (cmd.walk_init || cmd.walk_step),
        .wr_addr (cmd.walk_init ? NODE_W'(0) : len_reg[NODE_W-1:0]),
        .wr_data (cmd.walk_init ? end_reg : parent_rd),
        .rd_en   (cmd.emit_rd),
        .rd_addr (NODE_W'(len_reg - LEN_W'(1) - LEN_W'(k_reg))),
        .rd_data (stack_rd)
    );

    always_comb
    begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        u_next         = u_reg;
        e_next         = e_reg;
        pend_next      = pend_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        visited_next   = visited_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        if (add_en)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.accept && (req_data.op == OP_ADD) && a_ok && b_ok && full)
        begin
            drop_next = 1'b1;
        end
        if (cmd.accept && (req_data.op == OP_CLEAR))
        begin
            count_next = '0;
            drop_next  = 1'b0;
        end
        if (cmd.q_init)
        begin
            start_next                  = req_data.node_a;
            end_next                    = req_data.node_b;
            visited_next                = '0;
            visited_next[req_data.node_a] = 1'b1;
            head_next                   = '0;
            tail_next                   = LEN_W'(1);
        end
        if (cmd.deq_rd)
        begin
            head_next = head_reg + LEN_W'(1);
        end
        if (cmd.deq_load)
        begin
            u_next    = fifo_rd;
            e_next    = '0;
            pend_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            pend_next = issue;
            if (issue)
            begin
                e_next = e_reg + CW'(1);
            end
        end
        if (hit)
        begin
            visited_next[tgt] = 1'b1;
            tail_next         = tail_reg + LEN_W'(1);
        end
        if (cmd.walk_init)
        begin
            cur_next = end_reg;
            len_next = LEN_W'(1);
        end
        if (cmd.walk_step)
        begin
            cur_next = parent_rd;
            len_next = len_reg + LEN_W'(1);
        end
        if (cmd.emit_init)
        begin
            k_next = '0;
        end
        if (cmd.emit_load)
        begin
            k_next         = k_reg + NODE_W'(1);
            rsp_valid_next = 1'b1;
            rsp_next       = '{found: 1'b1, path_node: stack_rd, hop_index: k_reg,
                               last: last_hop, edges_dropped: drop_reg};
        end
        if (cmd.nf_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{found: 1'b0, path_node: '0, hop_index: '0,
                               last: 1'b1, edges_dropped: drop_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            e_reg         <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            visited_reg   <= '0;
            len_reg       <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            pend_reg      <= pend_next;
            e_reg         <= e_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            visited_reg   <= visited_next;
            len_reg       <= len_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        u_reg     <= u_next;
        cur_reg   <= cur_next;
        rsp_reg   <= rsp_next;
    end

    assign status.req_valid   = req_valid;
    assign status.req_op      = req_data.op;
    assign status.query_ok    = a_ok && b_ok;
    assign status.fifo_empty  = (head_reg == tail_reg);
    assign status.scan_done   = (e_reg == count_reg) && !pend_reg;
    assign status.end_visited = visited_reg[end_reg];
    assign status.walk_done   = (cur_reg == start_reg);
    assign status.emit_last   = last_hop;
    assign status.out_free    = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

[rtl/unit_weight_shortest_path.sv]
`default_nettype none

// breadth-first shortest path over a directed edge store. an add request
// writes one edge when both nodes are in range and the store is not full
// (an add to a full store sets the drop flag), and a clear request empties
// the store and its drop flag; both are accepted back to back. a query holds
// the block busy: for every node taken from the search queue the whole edge
// store is read once, one edge per cycle from a single memory port. each
// reached node takes a queue read, its load, the edge scan with its read
// pipeline drain and the scan end check; then a parent walk from the end
// node fills the path stack, and the emission reads it back. results leave
// through an output register, and the emission waits while that register
// holds a stalled result. no clearing pass is needed after reset.
module unit_weight_shortest_path #(
    parameter int NODES     = 64,
    parameter int MAX_EDGES = 1024
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // request channel
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire uwsp_pkg::req_t req_data,
    // result channel
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output uwsp_pkg::rsp_t      rsp_data
);

    import uwsp_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    busy;

    // sequencer: search, parent walk and result emission
    uwsp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // edge store, queue, visited bits, parents and path stack
    uwsp_dp #(.NODES(NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .rsp_stall (rsp_stall)
    );

    // requests are taken only while the sequencer is idle
    assign req_stall = busy;

`ifndef NO_ASSERTIONS
    // a query always makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_data.op == OP_QUERY) |=> req_stall)
        else $error("query did not start");

    // a path result and a not-found result are never loaded together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_load && cmd.nf_load))
        else $error("two results loaded at once");

    // while a non-final result is pending the query is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.last) |-> req_stall)
        else $error("query ended before its last result");
`endif

endmodule

`default_nettype wire
